FILE: rtl/stdd_pkg.sv
// ----------------------------------------------------------------------------
// stdd_pkg
// Shared types and constants of the sorted table with duplicate removal.
// ----------------------------------------------------------------------------
package stdd_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int HELD_W   = 6;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DEDUP  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_DEDUPED  = 3'd2;
  localparam logic [2:0] KIND_ENTRY    = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_DD_FIRST,
    ST_DD_SCAN,
    ST_DD_DONE,
    ST_RO_EMIT
  } stdd_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_EMIT_DROP,
    OP_EMIT_DEDUP,
    OP_EMIT_EMPTY,
    OP_INS_START,
    OP_INS_RD,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_SCAN_START,
    OP_DD_FIRST,
    OP_DD_SCAN,
    OP_DD_DONE,
    OP_RO_EMIT
  } stdd_op_t;

  typedef struct packed {
    logic     load_in;
    stdd_op_t op;
  } stdd_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic idx_zero;
    logic idx_one;
    logic ge;
    logic i_last;
  } stdd_stat_t;

endpackage

FILE: rtl/sorted_table_with_dedup_core.sv
// ----------------------------------------------------------------------------
// sorted_table_with_dedup_core
// Ascending table of signed words with insert, duplicate removal, read-out.
// ----------------------------------------------------------------------------
// A command word (in_func, in_value) is taken on a clock edge with start high
// and busy low. Results leave one per cycle on the out_ ports, each valid for
// exactly one cycle while out_strobe is high; out_last_of_run marks the final
// word of a command. The receiver cannot stall, so every result appears once.
// Steps from acceptance to the result shown, with n entries held:
//   insert: a read per entry compared, a shift up per entry at or above the
//     new value, then the write of it; on an empty table only the write
//   insert on a full table, removal or read-out on an empty table: result
//     the cycle after acceptance
//   duplicate removal: one memory read per entry scanned, then the result
//   read-out: n words back to back after the registered read of the first
// The entry memory has one registered read port and one write port.
// Func code 3 is taken and ignored. busy drops when the last result is being
// registered, so the next command may be accepted while it is still shown.
// Synchronous reset empties the table; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_with_dedup_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic signed [stdd_pkg::VAL_W-1:0] in_value,
  output logic                              out_strobe,
  output logic [2:0]                        out_kind,
  output logic signed [stdd_pkg::VAL_W-1:0] out_entry_value,
  output logic [stdd_pkg::HELD_W-1:0]       out_entries_held,
  output logic                              out_last_of_run
);
  import stdd_pkg::*;

  stdd_cmd_t  cmd;
  stdd_stat_t stat;

  stdd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  stdd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .stat             (stat),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_entry_value  (out_entry_value),
    .out_entries_held (out_entries_held),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

FILE: rtl/stdd_ctrl.sv
// ----------------------------------------------------------------------------
// stdd_ctrl
// Sequencer for insert, duplicate removal and in-order read-out.
// ----------------------------------------------------------------------------
module stdd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_func,
  input  stdd_pkg::stdd_stat_t stat,
  output stdd_pkg::stdd_cmd_t  cmd,
  output logic               busy
);
  import stdd_pkg::*;

  stdd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.load_in = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          unique case (in_func)
            FUNC_INSERT: begin
              if (stat.full) begin
                cmd.op = OP_EMIT_DROP;
              end else begin
                cmd.op    = OP_INS_START;
                state_nxt = ST_INS_RD;
              end
            end
            FUNC_DEDUP: begin
              if (stat.cnt_zero) begin
                cmd.op = OP_EMIT_DEDUP;
              end else begin
                cmd.op    = OP_SCAN_START;
                state_nxt = ST_DD_FIRST;
              end
            end
            FUNC_READ: begin
              if (stat.cnt_zero) begin
                cmd.op = OP_EMIT_EMPTY;
              end else begin
                cmd.op    = OP_SCAN_START;
                state_nxt = ST_RO_EMIT;
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.op    = OP_INS_PUT;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_INS_RD;
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // move an entry at or above the new value up one slot, else the hole is the spot
        if (stat.ge) begin
          cmd.op = OP_INS_SHIFT;
          if (stat.idx_one) begin
            state_nxt = ST_INS_PUT;
          end
        end else begin
          cmd.op    = OP_INS_PUT;
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        cmd.op    = OP_INS_PUT;
        state_nxt = ST_IDLE;
      end
      ST_DD_FIRST: begin
        cmd.op    = OP_DD_FIRST;
        state_nxt = stat.i_last ? ST_DD_DONE : ST_DD_SCAN;
      end
      ST_DD_SCAN: begin
        cmd.op = OP_DD_SCAN;
        if (stat.i_last) begin
          state_nxt = ST_DD_DONE;
        end
      end
      ST_DD_DONE: begin
        cmd.op    = OP_DD_DONE;
        state_nxt = ST_IDLE;
      end
      ST_RO_EMIT: begin
        cmd.op = OP_RO_EMIT;
        if (stat.i_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/stdd_dp.sv
// ----------------------------------------------------------------------------
// stdd_dp
// Entry memory, counters, compare logic and result register.
// ----------------------------------------------------------------------------
module stdd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stdd_pkg::stdd_cmd_t               cmd,
  input  logic signed [stdd_pkg::VAL_W-1:0] in_value,
  output stdd_pkg::stdd_stat_t              stat,
  output logic                              out_strobe,
  output logic [2:0]                        out_kind,
  output logic signed [stdd_pkg::VAL_W-1:0] out_entry_value,
  output logic [stdd_pkg::HELD_W-1:0]       out_entries_held,
  output logic                              out_last_of_run
);
  import stdd_pkg::*;

  logic signed [VAL_W-1:0] mem [CAPACITY];

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] last_r, last_nxt;
  logic signed [VAL_W-1:0] rdata_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;

  logic                    strobe_r, strobe_nxt;
  logic [2:0]              kind_r, kind_nxt;
  logic signed [VAL_W-1:0] ev_r, ev_nxt;
  logic [HELD_W-1:0]       held_r, held_nxt;
  logic                    lor_r, lor_nxt;

  logic                    rd_en, wr_en;
  logic [CNT_W-1:0]        rd_addr, wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  assign stat.full     = (count_r >= CNT_W'(CAPACITY));
  assign stat.cnt_zero = (count_r == '0);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_one  = (idx_r == CNT_W'(1));
  assign stat.ge       = (rdata_r >= val_r);
  assign stat.i_last   = ((i_r + CNT_W'(1)) == count_r);

  always_comb begin
    val_nxt    = cmd.load_in ? in_value : val_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    kept_nxt   = kept_r;
    i_nxt      = i_r;
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    ev_nxt     = ev_r;
    held_nxt   = held_r;
    lor_nxt    = lor_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rdata_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_EMIT_DROP, OP_EMIT_DEDUP, OP_EMIT_EMPTY: begin
        strobe_nxt = 1'b1;
        kind_nxt   = (cmd.op == OP_EMIT_DROP)  ? KIND_DROPPED :
                     (cmd.op == OP_EMIT_DEDUP) ? KIND_DEDUPED : KIND_EMPTY;
        ev_nxt     = '0;
        held_nxt   = HELD_W'(count_r);
        lor_nxt    = 1'b1;
      end
      OP_INS_START: idx_nxt = count_r;
      OP_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r - CNT_W'(1);
      end
      OP_INS_SHIFT: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r - CNT_W'(1);
        rd_en   = 1'b1;
        rd_addr = idx_r - CNT_W'(2);
      end
      OP_INS_PUT: begin
        wr_en      = 1'b1;
        wr_data    = val_r;
        count_nxt  = count_r + CNT_W'(1);
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_INSERTED;
        ev_nxt     = '0;
        held_nxt   = HELD_W'(count_r + CNT_W'(1));
        lor_nxt    = 1'b1;
      end
      OP_SCAN_START: begin
        rd_en    = 1'b1;
        rd_addr  = '0;
        i_nxt    = '0;
        kept_nxt = CNT_W'(1);
      end
      OP_DD_FIRST: begin
        last_nxt = rdata_r;
        i_nxt    = i_r + CNT_W'(1);
        rd_en    = 1'b1;
        rd_addr  = i_r + CNT_W'(1);
      end
      OP_DD_SCAN: begin
        // keep a word only when it differs from the last one kept
        if (rdata_r != last_r) begin
          wr_en    = 1'b1;
          wr_addr  = kept_r;
          last_nxt = rdata_r;
          kept_nxt = kept_r + CNT_W'(1);
        end
        i_nxt   = i_r + CNT_W'(1);
        rd_en   = 1'b1;
        rd_addr = i_r + CNT_W'(1);
      end
      OP_DD_DONE: begin
        count_nxt  = kept_r;
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_DEDUPED;
        ev_nxt     = '0;
        held_nxt   = HELD_W'(kept_r);
        lor_nxt    = 1'b1;
      end
      OP_RO_EMIT: begin
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_ENTRY;
        ev_nxt     = rdata_r;
        held_nxt   = HELD_W'(count_r);
        lor_nxt    = stat.i_last;
        i_nxt      = i_r + CNT_W'(1);
        rd_en      = 1'b1;
        rd_addr    = i_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    kept_r <= kept_nxt;
    i_r    <= i_nxt;
    kind_r <= kind_nxt;
    ev_r   <= ev_nxt;
    held_r <= held_nxt;
    lor_r  <= lor_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_kind         = kind_r;
  assign out_entry_value  = ev_r;
  assign out_entries_held = held_r;
  assign out_last_of_run  = lor_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INS_PUT) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table by one");

  a_empty_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_EMPTY) |-> (out_entries_held == '0))
    else $error("empty result with entries held");

  a_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_ENTRY) |-> (count_r != '0))
    else $error("read-out word from an empty table");

  a_no_drop_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT_DROP) |-> stat.full)
    else $error("drop with room left");
`endif

endmodule

FILE: sim/tb_sorted_table_with_dedup_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_with_dedup_core
// Self-checking bench for the sorted table with duplicate removal. A short
// directed table covers the empty table, the extreme values, equal values, a
// full table and the unused func code. Random traffic follows in three
// phases of sender idling. Every result word is compared with a local model
// of the table, or on typed directed rows with the row's own kind and count.
// ----------------------------------------------------------------------------
module tb_sorted_table_with_dedup_core;
  timeunit 1ns;
  timeprecision 1ps;

  import stdd_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int RAND_PER_PHASE = 150;

  typedef struct {
    logic [2:0]              kind;
    logic signed [VAL_W-1:0] val;
    logic [HELD_W-1:0]       held;
    logic                    last;
  } result_t;

  typedef struct {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;
    int                      rep;
    bit                      typed;
    logic [2:0]              kind;
    logic [HELD_W-1:0]       held;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_func;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_strobe;
  logic [2:0]              out_kind;
  logic signed [VAL_W-1:0] out_entry_value;
  logic [HELD_W-1:0]       out_entries_held;
  logic                    out_last_of_run;

  // local copy of the table
  logic signed [VAL_W-1:0] model_tbl [CAPACITY];
  int                      model_cnt;

  result_t fresh_results[$];
  result_t pending_results[$];
  int      errors;
  int      quiet_cycles;
  int      idle_pct;

  dir_row_t dir_rows [20] = '{
    '{FUNC_READ,   32'sh0000_0000,  1, 1'b1, KIND_EMPTY,    6'd0},
    '{FUNC_DEDUP,  32'sh0000_0000,  1, 1'b1, KIND_DEDUPED,  6'd0},
    '{FUNC_UNUSED, 32'sh5a5a_5a5a,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'sh7fff_ffff,  1, 1'b1, KIND_INSERTED, 6'd1},
    '{FUNC_INSERT, 32'sh8000_0000,  1, 1'b1, KIND_INSERTED, 6'd2},
    '{FUNC_INSERT, 32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'shffff_ffff,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'sh8000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'sh7fff_ffff,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_READ,   32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_DEDUP,  32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_READ,   32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_UNUSED, 32'shffff_ffff,  1, 1'b0, KIND_INSERTED, 6'd0},
    // four distinct entries left, fill up to capacity
    '{FUNC_INSERT, 32'sh0000_0005, 28, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'sh0000_0001,  1, 1'b1, KIND_DROPPED,  6'd32},
    '{FUNC_READ,   32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_DEDUP,  32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_READ,   32'sh0000_0000,  1, 1'b0, KIND_INSERTED, 6'd0},
    '{FUNC_INSERT, 32'sh0000_0003,  1, 1'b0, KIND_INSERTED, 6'd0}
  };

  sorted_table_with_dedup_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_entry_value  (out_entry_value),
    .out_entries_held (out_entries_held),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void add_result(logic [2:0] kind, logic signed [VAL_W-1:0] val,
                                     logic last);
    result_t r;
    r.kind = kind;
    r.val  = val;
    r.held = model_cnt[HELD_W-1:0];
    r.last = last;
    fresh_results.push_back(r);
  endfunction

  // updates the table copy and leaves the words this command causes
  function automatic void table_predict(logic [1:0] func, logic signed [VAL_W-1:0] value);
    int pos;
    int kept;
    fresh_results.delete();
    case (func)
      FUNC_INSERT: begin
        if (model_cnt >= CAPACITY) begin
          add_result(KIND_DROPPED, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < model_cnt && model_tbl[pos] < value) pos++;
          for (int i = model_cnt; i > pos; i--) model_tbl[i] = model_tbl[i-1];
          model_tbl[pos] = value;
          model_cnt++;
          add_result(KIND_INSERTED, '0, 1'b1);
        end
      end
      FUNC_DEDUP: begin
        if (model_cnt > 0) begin
          kept = 1;
          for (int i = 1; i < model_cnt; i++) begin
            if (model_tbl[i] != model_tbl[kept-1]) begin
              model_tbl[kept] = model_tbl[i];
              kept++;
            end
          end
          model_cnt = kept;
        end
        add_result(KIND_DEDUPED, '0, 1'b1);
      end
      FUNC_READ: begin
        if (model_cnt == 0) begin
          add_result(KIND_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < model_cnt; i++)
            add_result(KIND_ENTRY, model_tbl[i], (i + 1 == model_cnt));
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] func, input logic signed [VAL_W-1:0] value,
                           input bit typed, input logic [2:0] kind,
                           input logic [HELD_W-1:0] held);
    int      gap;
    result_t r;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 8);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_func  <= func;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    table_predict(func, value);
    if (typed) begin
      r.kind = kind;
      r.val  = '0;
      r.held = held;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
    end
  endtask

  // mostly small values so duplicates pile up, some extremes, some full range
  function automatic logic signed [VAL_W-1:0] pick_value();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return int'($urandom_range(0, 8)) - 4;
    if (mode < 7) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'shffff_ffff;
        default: return 32'sh0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic note_mismatch(input string what, input result_t exp_r);
    if (errors < 10) begin
      $display("mismatch (%s): exp kind=%0d val=%0d held=%0d last=%0b", what,
               exp_r.kind, exp_r.val, exp_r.held, exp_r.last);
      $display("              got kind=%0d val=%0d held=%0d last=%0b",
               out_kind, out_entry_value, out_entries_held, out_last_of_run);
    end
    errors++;
  endtask

  // result words, sampled on the edge that takes them
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        exp_r = '{3'd0, '0, '0, 1'b0};
        note_mismatch("unexpected word", exp_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_kind !== exp_r.kind || out_entry_value !== exp_r.val ||
            out_entries_held !== exp_r.held || out_last_of_run !== exp_r.last)
          note_mismatch("field", exp_r);
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int r;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_func      = FUNC_INSERT;
    in_value     = '0;
    errors       = 0;
    quiet_cycles = 0;
    idle_pct     = 0;
    model_cnt    = 0;
    foreach (model_tbl[i]) model_tbl[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].rep)
        send_word(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed,
                  dir_rows[i].kind, dir_rows[i].held);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 50;
        default: idle_pct = 10;
      endcase
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        if ($urandom_range(0, 24) == 0) begin
          // run the table up to full and one past it
          burst = CAPACITY - model_cnt + 1;
          repeat (burst) send_word(FUNC_INSERT, pick_value(), 1'b0, KIND_INSERTED, '0);
          sent += burst;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 62)
            send_word(FUNC_INSERT, pick_value(), 1'b0, KIND_INSERTED, '0);
          else if (r < 77)
            send_word(FUNC_DEDUP, $urandom, 1'b0, KIND_INSERTED, '0);
          else if (r < 93)
            send_word(FUNC_READ, $urandom, 1'b0, KIND_INSERTED, '0);
          else
            send_word(FUNC_UNUSED, $urandom, 1'b0, KIND_INSERTED, '0);
          sent++;
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
